>>> sv/glct_pkg.sv
// ----------------------------------------------------------------------------
// glct_pkg
// Shared types and constants for the grid line cell traversal block.
// ----------------------------------------------------------------------------
package glct_pkg;

   localparam int MAX_CELLS  = 64;
   localparam int COORD_BITS = 16;
   localparam int CELL_BITS  = 16;
   localparam int SIZE_BITS  = 15;
   // internal cell index: one sign bit and headroom over the coordinate range
   localparam int IDX_W      = COORD_BITS + 2;
   // crossing products: distance times extent, grown by up to MAX_CELLS steps
   localparam int PROD_W     = 2 * COORD_BITS + $clog2(MAX_CELLS) + 2;
   localparam int CNT_W      = $clog2(MAX_CELLS);
   localparam int DIV_CNT_W  = $clog2(COORD_BITS + 1);

   localparam logic [SIZE_BITS-1:0] CELL_SIZE_RESET = SIZE_BITS'(256);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_data_type;

   typedef struct packed {
      logic signed [CELL_BITS-1:0] cell_x;
      logic signed [CELL_BITS-1:0] cell_y;
      logic                        last;
      logic                        overflow;
   } rsp_data_type;

   typedef struct packed {
      logic signed [IDX_W-1:0] cx;
      logic signed [IDX_W-1:0] cy;
      logic signed [IDX_W-1:0] ex;
      logic signed [IDX_W-1:0] ey;
      logic [PROD_W-1:0]       tx;
      logic [PROD_W-1:0]       ty;
      logic [PROD_W-1:0]       dtx;
      logic [PROD_W-1:0]       dty;
      logic                    sx_neg;
      logic                    sy_neg;
   } job_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

endpackage

>>> sv/glct_div.sv
// ----------------------------------------------------------------------------
// glct_div
// Bit-serial floor division of a signed coordinate by the cell size.
// ----------------------------------------------------------------------------
module glct_div
   import glct_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] dividend,
   input  logic [SIZE_BITS-1:0]         divisor,
   output logic                         idle,
   output logic signed [IDX_W-1:0]      quotient,
   output logic [COORD_BITS-1:0]        remainder
);

   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [COORD_BITS-1:0] rem_shift;
   logic                  ge;
   logic [IDX_W-1:0]      q_wide;

   always_comb begin
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      rem_shift = {rem_ff[COORD_BITS-2:0], quo_ff[COORD_BITS-1]};
      ge        = rem_shift >= COORD_BITS'(divisor);
      if (start) begin
         cnt_in = DIV_CNT_W'(COORD_BITS);
         neg_in = dividend[COORD_BITS-1];
         quo_in = dividend[COORD_BITS-1] ? COORD_BITS'(-dividend) : COORD_BITS'(dividend);
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = ge ? rem_shift - COORD_BITS'(divisor) : rem_shift;
         quo_in = {quo_ff[COORD_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // floor fixup for negative dividends
   always_comb begin
      q_wide = IDX_W'(quo_ff);
      if (neg_ff) begin
         quotient  = (rem_ff != '0) ? $signed(-q_wide - 1'b1) : $signed(-q_wide);
         remainder = (rem_ff != '0) ? COORD_BITS'(divisor) - rem_ff : '0;
      end else begin
         quotient  = $signed(q_wide);
         remainder = rem_ff;
      end
   end

   assign idle = (cnt_ff == '0);

endmodule

>>> sv/glct_front.sv
// ----------------------------------------------------------------------------
// glct_front
// Accepts a segment, finds start and end cells and the crossing products.
// ----------------------------------------------------------------------------
module glct_front
   import glct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_data_type         req_data,
   input  logic [SIZE_BITS-1:0] cell_size,
   output logic                 busy,
   input  logic                 queue_full,
   output logic                 push,
   output job_type              job
);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_MUL, F_PUSH} state_type;

   state_type               state_ff;
   logic [SIZE_BITS-1:0]    s_ff;
   logic [COORD_BITS-1:0]   ax_ff, ay_ff, bx_ff, by_ff;
   logic                    dx_pos_ff, dy_pos_ff, dx_neg_ff, dy_neg_ff;
   job_type                 job_ff;
   logic                    accept;
   logic [SIZE_BITS-1:0]    s_eff;
   logic signed [COORD_BITS:0] dx, dy;
   logic                    idle_x0, idle_y0, idle_x1, idle_y1;
   logic signed [IDX_W-1:0] q_x0, q_y0, q_x1, q_y1;
   logic [COORD_BITS-1:0]   r_x0, r_y0, r_x1, r_y1;

   assign accept = start && (state_ff == F_IDLE);
   assign s_eff  = (cell_size == '0) ? SIZE_BITS'(1) : cell_size;
   assign dx = {req_data.end_x[COORD_BITS-1], req_data.end_x}
             - {req_data.start_x[COORD_BITS-1], req_data.start_x};
   assign dy = {req_data.end_y[COORD_BITS-1], req_data.end_y}
             - {req_data.start_y[COORD_BITS-1], req_data.start_y};

   glct_div u_div_x0 (.clock, .reset, .start(accept), .dividend(req_data.start_x),
                      .divisor(s_eff), .idle(idle_x0), .quotient(q_x0), .remainder(r_x0));
   glct_div u_div_y0 (.clock, .reset, .start(accept), .dividend(req_data.start_y),
                      .divisor(s_eff), .idle(idle_y0), .quotient(q_y0), .remainder(r_y0));
   glct_div u_div_x1 (.clock, .reset, .start(accept), .dividend(req_data.end_x),
                      .divisor(s_eff), .idle(idle_x1), .quotient(q_x1), .remainder(r_x1));
   glct_div u_div_y1 (.clock, .reset, .start(accept), .dividend(req_data.end_y),
                      .divisor(s_eff), .idle(idle_y1), .quotient(q_y1), .remainder(r_y1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: if (accept) state_ff <= F_DIV;
            F_DIV:  if (idle_x0 && idle_y0 && idle_x1 && idle_y1) state_ff <= F_MUL;
            F_MUL:  state_ff <= F_PUSH;
            F_PUSH: if (!queue_full) state_ff <= F_IDLE;
            default: state_ff <= F_IDLE;
         endcase
      end
      if (accept) begin
         s_ff      <= s_eff;
         dx_pos_ff <= (dx > 0);
         dy_pos_ff <= (dy > 0);
         dx_neg_ff <= !(dx > 0);
         dy_neg_ff <= !(dy > 0);
         ax_ff     <= dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
         ay_ff     <= dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
      end
      if (state_ff == F_DIV) begin
         // distance from start point to the first grid line in each direction
         bx_ff     <= dx_pos_ff ? COORD_BITS'(s_ff) - r_x0 : r_x0;
         by_ff     <= dy_pos_ff ? COORD_BITS'(s_ff) - r_y0 : r_y0;
         job_ff.cx <= q_x0;
         job_ff.cy <= q_y0;
         job_ff.ex <= q_x1;
         job_ff.ey <= q_y1;
         job_ff.sx_neg <= dx_neg_ff;
         job_ff.sy_neg <= dy_neg_ff;
      end
      if (state_ff == F_MUL) begin
         job_ff.tx  <= PROD_W'(bx_ff * ay_ff);
         job_ff.ty  <= PROD_W'(by_ff * ax_ff);
         job_ff.dtx <= PROD_W'(COORD_BITS'(s_ff) * ay_ff);
         job_ff.dty <= PROD_W'(COORD_BITS'(s_ff) * ax_ff);
      end
   end

   assign busy = (state_ff != F_IDLE);
   assign push = (state_ff == F_PUSH) && !queue_full;
   assign job  = job_ff;

endmodule

>>> sv/glct_queue.sv
// ----------------------------------------------------------------------------
// glct_queue
// Two-entry job queue between the setup front and the walking back.
// ----------------------------------------------------------------------------
module glct_queue
   import glct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  queue_ctl_type ctl_in,
   output queue_ctl_type ctl_out,
   input  job_type       wr_job,
   output job_type       rd_job
);

   job_type     entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        do_push, do_pop;

   assign do_push = ctl_in.push && (count_ff != 2'd2);
   assign do_pop  = ctl_in.pop && (count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) entry_ff[wr_ptr_ff] <= wr_job;
   end

   assign rd_job        = entry_ff[rd_ptr_ff];
   assign ctl_out.push  = do_push;
   assign ctl_out.pop   = do_pop;
   assign ctl_out.full  = (count_ff == 2'd2);
   assign ctl_out.empty = (count_ff == 2'd0);

endmodule

>>> sv/glct_back.sv
// ----------------------------------------------------------------------------
// glct_back
// Walks one job cell by cell and drives the result strobe.
// ----------------------------------------------------------------------------
module glct_back
   import glct_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         queue_empty,
   output logic         pop,
   input  job_type      job,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   typedef enum logic {B_IDLE, B_WALK} state_type;

   state_type               state_ff;
   job_type                 cur_ff;
   logic [CNT_W-1:0]        n_ff;
   logic                    rsp_valid_ff;
   rsp_data_type            rsp_data_ff;
   logic                    at_end, cut, step_x, x_free, y_free;

   assign pop    = (state_ff == B_IDLE) && !queue_empty;
   assign x_free = (cur_ff.cx != cur_ff.ex);
   assign y_free = (cur_ff.cy != cur_ff.ey);
   assign at_end = !x_free && !y_free;
   assign cut    = (n_ff == CNT_W'(MAX_CELLS - 1));

   // ties step y
   always_comb begin
      if (!y_free)      step_x = 1'b1;
      else if (!x_free) step_x = 1'b0;
      else              step_x = cur_ff.tx < cur_ff.ty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == B_WALK);
         case (state_ff)
            B_IDLE: if (pop) state_ff <= B_WALK;
            B_WALK: if (at_end || cut) state_ff <= B_IDLE;
            default: state_ff <= B_IDLE;
         endcase
      end
      if (pop) begin
         cur_ff <= job;
         n_ff   <= '0;
      end else if (state_ff == B_WALK) begin
         n_ff <= n_ff + 1'b1;
         if (step_x) begin
            cur_ff.cx <= cur_ff.sx_neg ? cur_ff.cx - 1'b1 : cur_ff.cx + 1'b1;
            cur_ff.tx <= cur_ff.tx + cur_ff.dtx;
         end else begin
            cur_ff.cy <= cur_ff.sy_neg ? cur_ff.cy - 1'b1 : cur_ff.cy + 1'b1;
            cur_ff.ty <= cur_ff.ty + cur_ff.dty;
         end
      end
      rsp_data_ff.cell_x   <= cur_ff.cx[CELL_BITS-1:0];
      rsp_data_ff.cell_y   <= cur_ff.cy[CELL_BITS-1:0];
      rsp_data_ff.last     <= at_end || cut;
      rsp_data_ff.overflow <= cut && !at_end;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.last)
      else $error("overflow without last");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> state_ff == B_IDLE)
      else $error("walk continues past last cell");
   a_no_pop_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_WALK |-> !pop)
      else $error("pop while walking");
`endif

endmodule

>>> sv/grid_line_cell_traversal.sv
// ----------------------------------------------------------------------------
// grid_line_cell_traversal
// Emits every grid cell a line segment passes through, start to end.
// ----------------------------------------------------------------------------
//  channel  ports                          transfer
//  req      start, busy, req_data          start high and busy low at an edge
//  rsp      rsp_valid, rsp_data            one cycle per cell, no back pressure
//  csr      csr_psel .. csr_prdata         APB read and write, pready always high
//
// After a transfer busy stays high through F_DIV, where the serial dividers
// step once per quotient bit, F_MUL to multiply and F_PUSH to push the job;
// F_PUSH waits while the queue is full. The first cell strobes once the walker
// has popped the job into B_WALK, through the registered rsp_valid; then one
// cell per cycle (up to 64), with B_IDLE between segments. The 2-entry job
// queue lets the front set up the next segment while the back still walks.
// Reset is synchronous; cell_size returns to 256 and the queue empties.
// ----------------------------------------------------------------------------
module grid_line_cell_traversal
   import glct_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_valid,
   output rsp_data_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [SIZE_BITS-1:0] cell_size_ff;
   queue_ctl_type        q_in, q_out;
   job_type              front_job, back_job;
   logic                 front_push, back_pop;

   // hold cell size; addresses 0 to 3 alias the one register, 4 to 7 drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CELL_SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         cell_size_ff <= csr_pwdata[SIZE_BITS-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(cell_size_ff);

   glct_front u_front (
      .clock, .reset, .start, .req_data,
      .cell_size(cell_size_ff), .busy,
      .queue_full(q_out.full), .push(front_push), .job(front_job)
   );

   assign q_in.push  = front_push;
   assign q_in.pop   = back_pop;
   assign q_in.full  = 1'b0;
   assign q_in.empty = 1'b0;

   glct_queue u_queue (
      .clock, .reset, .ctl_in(q_in), .ctl_out(q_out),
      .wr_job(front_job), .rd_job(back_job)
   );

   glct_back u_back (
      .clock, .reset, .queue_empty(q_out.empty), .pop(back_pop),
      .job(back_job), .rsp_valid, .rsp_data
   );

endmodule
